### sv/assert_macros.svh
// Assertion macros shared by the frame engine RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while rst is high.
`define LFX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define LFX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/lfx_pkg.sv
// Package for the LED effect frame engine: constants, codes, word types and
// the chain order table. Depends on nothing.
package lfx_pkg;

  localparam int NUM_LEDS   = 6;
  localparam int LED_IDX_W  = $clog2(NUM_LEDS);
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [7:0] MIN_PERIOD     = 8'd5;
  localparam logic [7:0] RESET_COLOUR   = 8'd255;
  localparam logic [7:0] RESET_PERIOD   = 8'd50;
  localparam logic [7:0] RESET_BRIGHT   = 8'd48;

  typedef enum logic [1:0] {
    FX_OFF    = 2'd0,
    FX_STEADY = 2'd1,
    FX_BLINK  = 2'd2,
    FX_PULSE  = 2'd3
  } fx_t;

  typedef enum logic [1:0] {
    CMD_SET_ONE = 2'd0,
    CMD_SET_ALL = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_MOD_WAIT,
    ST_LEVEL,
    ST_PDIV_WAIT,
    ST_RED,
    ST_GREEN,
    ST_BLUE,
    ST_EMIT
  } st_t;

  typedef struct packed {
    fx_t        effect;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] period;
    logic [7:0] brightness;
  } led_entry_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] led_index;
    logic [7:0] effect_code;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] period_in;
    logic [7:0] brightness_in;
  } lfx_in_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       frame_last;
  } lfx_out_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quotient;
    logic [7:0]  remainder;
  } div_rsp_t;

  function automatic logic [LED_IDX_W-1:0] chain_led(input logic [LED_IDX_W-1:0] pos);
    logic [LED_IDX_W-1:0] led;
    case (pos)
      LED_IDX_W'(0): led = LED_IDX_W'(2);
      LED_IDX_W'(1): led = LED_IDX_W'(1);
      LED_IDX_W'(2): led = LED_IDX_W'(0);
      LED_IDX_W'(3): led = LED_IDX_W'(5);
      LED_IDX_W'(4): led = LED_IDX_W'(4);
      LED_IDX_W'(5): led = LED_IDX_W'(3);
      default:       led = LED_IDX_W'(0);
    endcase
    return led;
  endfunction

endpackage

### sv/led_effect_frame_engine_core.sv
// Top level of the LED effect frame engine: command sequencer, shared
// multiplier and output register. Depends on lfx_pkg, lfx_div, lfx_settings
// and assert_macros.svh.
//
// One command word enters on the input channel when in_valid is high and
// in_stall is low. The settings or the tick counter change at that edge, and
// then a frame of six pixel words leaves on the output channel in the chain
// order 2,1,0,5,4,3, the last one with frame_last set.
// Every pixel runs through the shared 16-step divider once for the tick phase,
// and once more for a pulse level, then the shared multiplier three times for
// the colour scaling.
// in_stall stays high from acceptance until the last pixel word is loaded.
// The output register lets the next pixel be computed while the previous one
// waits; a stall on the output channel holds the sequencer in its emit step.
// After reset all LEDs are steady white, period 50, brightness 48, the tick
// is zero, and no word is pending.
`include "assert_macros.svh"
module led_effect_frame_engine_core import lfx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  lfx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lfx_out_t out_data
);

  localparam logic [LED_IDX_W-1:0] LAST_POS = LED_IDX_W'(NUM_LEDS - 1);

  st_t                  state;
  st_t                  state_next;
  logic [LED_IDX_W-1:0] pos;
  logic [7:0]           ph;
  logic [7:0]           lv;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;

  led_entry_t           cur;
  logic [15:0]          tick;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic [7:0]           half;
  logic [7:0]           blink_on;
  logic [8:0]           blink_sum;
  logic                 ph_up;
  logic [7:0]           lv_direct;
  logic [7:0]           mul_a;
  logic [7:0]           mul_b;
  logic [15:0]          product;
  logic [16:0]          scaled;
  logic [7:0]           sc8;

  lfx_settings u_settings (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_accept),
    .wr_data  (in_data),
    .rd_index (chain_led(pos)),
    .rd_entry (cur),
    .tick     (tick)
  );

  lfx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    half      = {1'b0, cur.period[7:1]};
    blink_sum = {1'b0, cur.period} + 9'd1;
    blink_on  = blink_sum[8:1];
    ph_up     = ph <= half;
    case (cur.effect)
      FX_STEADY: lv_direct = cur.brightness;
      FX_BLINK:  lv_direct = (ph < blink_on) ? cur.brightness : 8'd0;
      default:   lv_direct = 8'd0;
    endcase
  end

  always_comb begin
    case (state)
      ST_LEVEL: begin
        mul_a = cur.brightness;
        mul_b = ph_up ? ph : (cur.period - ph);
      end
      ST_RED: begin
        mul_a = cur.red;
        mul_b = lv;
      end
      ST_GREEN: begin
        mul_a = cur.green;
        mul_b = lv;
      end
      ST_BLUE: begin
        mul_a = cur.blue;
        mul_b = lv;
      end
      default: begin
        mul_a = 8'd0;
        mul_b = 8'd0;
      end
    endcase
    product = mul_a * mul_b;
    scaled  = {1'b0, product} + 17'd1 + 17'(product[15:8]);
    sc8     = scaled[15:8];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_accept) state_next = ST_MOD;
      ST_MOD:       state_next = ST_MOD_WAIT;
      ST_MOD_WAIT:  if (div_rsp.done) state_next = ST_LEVEL;
      ST_LEVEL:     state_next = (cur.effect == FX_PULSE) ? ST_PDIV_WAIT : ST_RED;
      ST_PDIV_WAIT: if (div_rsp.done) state_next = ST_RED;
      ST_RED:       state_next = ST_GREEN;
      ST_GREEN:     state_next = ST_BLUE;
      ST_BLUE:      state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = (pos == LAST_POS) ? ST_IDLE : ST_MOD;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != ST_IDLE;
    out_load = (state == ST_EMIT) && out_free;
    div_req  = '{start: 1'b0, dividend: 16'd0, divisor: 8'd0};
    case (state)
      ST_MOD: begin
        div_req = '{start: 1'b1, dividend: tick, divisor: cur.period};
      end
      ST_LEVEL: begin
        div_req = '{start: cur.effect == FX_PULSE, dividend: product,
                    divisor: ph_up ? half : (cur.period - half)};
      end
      default: begin
        div_req = '{start: 1'b0, dividend: 16'd0, divisor: 8'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        pos <= '0;
      end else if (out_load) begin
        pos <= (pos == LAST_POS) ? '0 : pos + LED_IDX_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD_WAIT && div_rsp.done) ph <= div_rsp.remainder;
    if (state == ST_LEVEL && cur.effect != FX_PULSE) lv <= lv_direct;
    if (state == ST_PDIV_WAIT && div_rsp.done) lv <= div_rsp.quotient[7:0];
    if (state == ST_RED) red <= sc8;
    if (state == ST_GREEN) green <= sc8;
    if (state == ST_BLUE) blue <= sc8;
    if (out_load) begin
      out_data <= '{pixel_red: red, pixel_green: green, pixel_blue: blue,
                    frame_last: pos == LAST_POS};
    end
  end

  `LFX_ASSERT(a_div_done_waited, div_rsp.done |-> (state == ST_MOD_WAIT || state == ST_PDIV_WAIT), "divider finished outside a wait step")
  `LFX_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `LFX_ASSERT(a_accept_starts, in_accept |=> (state == ST_MOD && pos == '0), "accepted word did not start a frame")
  `LFX_ASSERT(a_last_ends_frame, (out_load && pos == LAST_POS) |=> (state == ST_IDLE && out_data.frame_last), "last pixel did not close the frame")
  `LFX_ASSERT(a_level_bound, (state == ST_RED) |-> (lv <= cur.brightness), "level above brightness")

endmodule

### sv/lfx_div.sv
// Shared restoring divider, one quotient bit per cycle, 16-bit by 8-bit.
// Depends on lfx_pkg for the request and response word types.
module lfx_div import lfx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          quo;
  logic [7:0]           rem;
  logic [7:0]           dsr;
  logic [8:0]           trial;
  logic                 ge;
  logic [8:0]           diff;
  logic [7:0]           rem_next;

  always_comb begin
    trial    = {rem, quo[15]};
    ge       = trial >= {1'b0, dsr};
    diff     = trial - {1'b0, dsr};
    rem_next = ge ? diff[7:0] : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[14:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: quo, remainder: rem};

endmodule

### sv/lfx_settings.sv
// Per-LED settings registers and the wrapping tick counter, updated by one
// command word. Depends on lfx_pkg for the entry and input word types.
module lfx_settings import lfx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  lfx_in_t              wr_data,
  input  logic [LED_IDX_W-1:0] rd_index,
  output led_entry_t           rd_entry,
  output logic [15:0]          tick
);

  led_entry_t entry [NUM_LEDS];
  led_entry_t new_entry;

  always_comb begin
    new_entry.effect     = (wr_data.effect_code <= 8'(FX_PULSE)) ?
                           fx_t'(wr_data.effect_code[1:0]) : FX_OFF;
    new_entry.red        = wr_data.red_in;
    new_entry.green      = wr_data.green_in;
    new_entry.blue       = wr_data.blue_in;
    new_entry.period     = (wr_data.period_in < MIN_PERIOD) ? MIN_PERIOD : wr_data.period_in;
    new_entry.brightness = wr_data.brightness_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        entry[i] <= '{effect: FX_STEADY, red: RESET_COLOUR, green: RESET_COLOUR,
                      blue: RESET_COLOUR, period: RESET_PERIOD, brightness: RESET_BRIGHT};
      end
    end else if (wr_en) begin
      case (cmd_t'(wr_data.command))
        CMD_SET_ONE: begin
          if (wr_data.led_index < 8'(NUM_LEDS)) begin
            entry[wr_data.led_index[LED_IDX_W-1:0]] <= new_entry;
          end
        end
        CMD_SET_ALL: begin
          for (int i = 0; i < NUM_LEDS; i++) begin
            entry[i] <= new_entry;
          end
        end
        CMD_ALL_OFF: begin
          for (int i = 0; i < NUM_LEDS; i++) begin
            entry[i].effect <= FX_OFF;
          end
        end
        CMD_TICK: begin
          tick <= tick + 16'd1;
        end
        default: begin
          tick <= tick;
        end
      endcase
    end
  end

  assign rd_entry = entry[rd_index];

endmodule

### bench/tb_led_effect_frame_engine_core.sv
// Self-checking testbench for led_effect_frame_engine_core: a directed table, then random
// command words, each checked against a predictor of the LED settings and tick counter.
// Depends on lfx_pkg and the engine RTL.
module tb_led_effect_frame_engine_core;
  import lfx_pkg::*;

  typedef struct {
    lfx_in_t    word;
    logic       typed;
    logic [7:0] level_all;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lfx_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lfx_out_t out_data;
  logic     calm = 1'b0;

  led_entry_t  lamp_state [NUM_LEDS];
  logic [15:0] tick_now;
  lfx_out_t    pixel_queue [$];
  stim_row_t   directed_rows [$];

  int mismatches = 0;
  int pixels_seen = 0;
  int n_words = 0;
  int n_ticks = 0;
  int n_set_one = 0;
  int n_set_all = 0;
  int n_all_off = 0;

  led_effect_frame_engine_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned lamp_level(led_entry_t e);
    int unsigned p, ph, b, h;
    p = (e.period < MIN_PERIOD) ? MIN_PERIOD : e.period;
    ph = tick_now % p;
    b = e.brightness;
    h = p >> 1;
    case (e.effect)
      FX_STEADY: return b;
      FX_BLINK: return (ph < ((p + 1) >> 1)) ? b : 0;
      FX_PULSE: begin
        if (ph <= h) return (b * ph) / h;
        return (b * (p - ph)) / (p - h);
      end
      default: return 0;
    endcase
  endfunction

  function automatic void store_lamp(int led, lfx_in_t w);
    lamp_state[led].effect = (w.effect_code <= 8'(FX_PULSE)) ?
                             fx_t'(w.effect_code[1:0]) : FX_OFF;
    lamp_state[led].red = w.red_in;
    lamp_state[led].green = w.green_in;
    lamp_state[led].blue = w.blue_in;
    lamp_state[led].period = (w.period_in < MIN_PERIOD) ? MIN_PERIOD : w.period_in;
    lamp_state[led].brightness = w.brightness_in;
  endfunction

  task automatic predict_frame(input lfx_in_t w, input logic typed, input logic [7:0] lvl);
    led_entry_t  e;
    lfx_out_t    px;
    int          pos, led;
    int unsigned lv;
    n_words++;
    case (cmd_t'(w.command))
      CMD_SET_ONE: begin
        n_set_one++;
        if (w.led_index < NUM_LEDS) store_lamp(w.led_index, w);
      end
      CMD_SET_ALL: begin
        n_set_all++;
        for (led = 0; led < NUM_LEDS; led++) store_lamp(led, w);
      end
      CMD_ALL_OFF: begin
        n_all_off++;
        for (led = 0; led < NUM_LEDS; led++) lamp_state[led].effect = FX_OFF;
      end
      default: begin
        n_ticks++;
        tick_now = tick_now + 16'd1;
      end
    endcase
    for (pos = 0; pos < NUM_LEDS; pos++) begin
      // The chain runs 2,1,0 then 5,4,3.
      led = (pos < 3) ? 2 - pos : 8 - pos;
      e = lamp_state[led];
      lv = lamp_level(e);
      px.pixel_red = 8'((e.red * lv) / 255);
      px.pixel_green = 8'((e.green * lv) / 255);
      px.pixel_blue = 8'((e.blue * lv) / 255);
      if (typed) begin
        px.pixel_red = lvl;
        px.pixel_green = lvl;
        px.pixel_blue = lvl;
      end
      px.frame_last = (pos == NUM_LEDS - 1);
      pixel_queue.push_back(px);
    end
  endtask

  task automatic check_pixel(input lfx_out_t got);
    lfx_out_t want;
    pixels_seen++;
    if (pixel_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected pixel word: r=%0d g=%0d b=%0d last=%0b",
                 got.pixel_red, got.pixel_green, got.pixel_blue, got.frame_last);
    end else begin
      want = pixel_queue.pop_front();
      if (got.pixel_red !== want.pixel_red || got.pixel_green !== want.pixel_green ||
          got.pixel_blue !== want.pixel_blue || got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b, ",
                    "got r=%0d g=%0d b=%0d last=%0b"},
                   want.pixel_red, want.pixel_green, want.pixel_blue, want.frame_last,
                   got.pixel_red, got.pixel_green, got.pixel_blue, got.frame_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pixel(out_data);
      out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  function automatic stim_row_t make_row(cmd_t cmd, logic [7:0] idx, logic [7:0] fx,
                                         logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] per, logic [7:0] bright,
                                         logic typed, logic [7:0] lvl);
    stim_row_t s;
    s.word.command = cmd;
    s.word.led_index = idx;
    s.word.effect_code = fx;
    s.word.red_in = r;
    s.word.green_in = g;
    s.word.blue_in = b;
    s.word.period_in = per;
    s.word.brightness_in = bright;
    s.typed = typed;
    s.level_all = lvl;
    return s;
  endfunction

  function automatic lfx_in_t random_word();
    lfx_in_t     w;
    int unsigned pick;
    w.led_index = 8'($urandom_range(0, 255));
    w.effect_code = 8'($urandom_range(0, 255));
    w.red_in = 8'($urandom_range(0, 255));
    w.green_in = 8'($urandom_range(0, 255));
    w.blue_in = 8'($urandom_range(0, 255));
    w.period_in = 8'($urandom_range(0, 255));
    w.brightness_in = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.command = CMD_TICK;
    end else if (pick < 85) begin
      w.command = CMD_SET_ONE;
      if ($urandom_range(0, 9) != 0) w.led_index = 8'($urandom_range(0, NUM_LEDS - 1));
    end else if (pick < 95) begin
      w.command = CMD_SET_ALL;
    end else begin
      w.command = CMD_ALL_OFF;
    end
    if ($urandom_range(0, 7) != 0) w.effect_code = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0) w.period_in = 8'($urandom_range(0, 16));
    return w;
  endfunction

  task automatic send_word(input lfx_in_t w, input logic typed, input logic [7:0] lvl);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 260)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(w, typed, lvl);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    stim_row_t s;
    int        k;
    for (k = 0; k < NUM_LEDS; k++) begin
      lamp_state[k].effect = FX_STEADY;
      lamp_state[k].red = RESET_COLOUR;
      lamp_state[k].green = RESET_COLOUR;
      lamp_state[k].blue = RESET_COLOUR;
      lamp_state[k].period = RESET_PERIOD;
      lamp_state[k].brightness = RESET_BRIGHT;
    end
    tick_now = '0;

    directed_rows.push_back(make_row(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                     8'hFF, 1'b1, 8'd48));
    directed_rows.push_back(make_row(CMD_SET_ALL, 8'd0, 8'(FX_STEADY), 8'd255, 8'd255,
                                     8'd255, 8'd0, 8'd255, 1'b1, 8'd255));
    directed_rows.push_back(make_row(CMD_ALL_OFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                     8'd0, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd255, 8'(FX_STEADY), 8'd255, 8'd255,
                                     8'd255, 8'd50, 8'd255, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd6, 8'(FX_STEADY), 8'd255, 8'd255,
                                     8'd255, 8'd50, 8'd255, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ALL, 8'd0, 8'hFF, 8'd255, 8'd255, 8'd255,
                                     8'd255, 8'd255, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ALL, 8'd0, 8'(FX_STEADY), 8'd0, 8'd0, 8'd0,
                                     8'd50, 8'd255, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ALL, 8'd0, 8'(FX_STEADY), 8'd255, 8'd255,
                                     8'd255, 8'd50, 8'd0, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ALL, 8'd0, 8'(FX_STEADY), 8'hAA, 8'h55, 8'hFF,
                                     8'd4, 8'd200, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_ALL_OFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                     8'd0, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                     8'd0, 1'b1, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd0, 8'(FX_STEADY), 8'hAA, 8'h55, 8'hCC,
                                     8'd7, 8'd128, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd1, 8'(FX_BLINK), 8'h12, 8'h34, 8'h56,
                                     8'd5, 8'd255, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd2, 8'(FX_PULSE), 8'hFF, 8'h80, 8'h01,
                                     8'd4, 8'd255, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd3, 8'(FX_PULSE), 8'h55, 8'hAA, 8'h0F,
                                     8'd255, 8'd99, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd4, 8'(FX_BLINK), 8'hF0, 8'h0F, 8'h3C,
                                     8'd6, 8'd77, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd5, 8'(FX_PULSE), 8'h01, 8'hFE, 8'h7F,
                                     8'd9, 8'd180, 1'b0, 8'd0));
    for (k = 0; k < 6; k++)
      directed_rows.push_back(make_row(CMD_TICK, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h0F, 8'hF0,
                                       8'h3C, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_SET_ONE, 8'd5, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'd20,
                                     8'd255, 1'b0, 8'd0));
    directed_rows.push_back(make_row(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                     8'd0, 1'b0, 8'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      s = directed_rows[k];
      send_word(s.word, s.typed, s.level_all);
    end
    wait_drained();

    for (k = 0; k < 420; k++) begin
      calm <= (k >= 150 && k < 230);
      send_word(random_word(), 1'b0, 8'd0);
      if (k == 300) wait_drained();
    end

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Sent %0d command words: %0d ticks, %0d set-one, %0d set-all, %0d all-off.",
             n_words, n_ticks, n_set_one, n_set_all, n_all_off);
    $display("Checked %0d pixel words with %0d mismatches; tick count ended at %0d.",
             pixels_seen, mismatches, tick_now);
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
